// ----- design/dsce_pkg.sv -----
`timescale 1ns / 1ps
package dsce_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int KC_W      = 2;
  localparam int WIN_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAST_WINDOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FUTURE_WINDOW = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_AGE   = 3'd7;

  localparam logic [1:0] ST_GENERATED     = 2'd0;
  localparam logic [1:0] ST_INVALID       = 2'd1;
  localparam logic [1:0] ST_VALID         = 2'd2;
  localparam logic [1:0] ST_VALID_REFRESH = 2'd3;

  localparam logic       FUNC_GENERATE = 1'b0;
  localparam logic       FAMILY_IPV6   = 1'b1;

  localparam logic [7:0] COOKIE_VERSION = 8'h01;
  localparam logic [5:0] COOKIE_BYTES   = 6'd16;
  localparam logic [7:0] MSG_LEN_V4     = 8'd20;
  localparam logic [7:0] MSG_LEN_V6     = 8'd32;
  localparam logic [2:0] LAST_BLK_V4    = 3'd2;
  localparam logic [2:0] LAST_BLK_V6    = 3'd4;

  localparam logic [63:0] SIP_C0  = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1  = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2  = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3  = 64'h7465646279746573;
  localparam logic [63:0] FIN_XOR = 64'h00000000000000FF;

  typedef struct packed {
    logic        func;
    logic        addr_family;
    logic [63:0] client_addr_high;
    logic [63:0] client_addr_low;
    logic [63:0] cli_cookie;
    logic [63:0] cookie_header;
    logic [63:0] received_hash;
    logic [5:0]  cookie_len;
    logic [31:0] time_now;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] header_out;
    logic [63:0] mac_out;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AGE,
    S_WINDOW,
    S_INIT,
    S_ABS0,
    S_ABS1,
    S_FINAL,
    S_CMP,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    SIP_NOP,
    SIP_INIT,
    SIP_ABSORB0,
    SIP_ABSORB1,
    SIP_ROUND
  } sip_op_t;

  typedef struct packed {
    sip_op_t     op;
    logic [63:0] m;
    logic        fin;
  } sip_cmd_t;

  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[56 - 8*i +: 8];
    end
    return r;
  endfunction

  // little-endian message words: cookie, header, address, length block
  function automatic logic [63:0] msg_block(input in_t it, input logic [63:0] hdr,
                                            input logic [2:0] idx);
    logic [63:0] w;
    case (idx)
      3'd0: w = bswap64(it.cli_cookie);
      3'd1: w = bswap64(hdr);
      3'd2: begin
        if (it.addr_family == FAMILY_IPV6) begin
          w = bswap64(it.client_addr_high);
        end else begin
          w = {MSG_LEN_V4, 24'd0, it.client_addr_high[39:32], it.client_addr_high[47:40],
               it.client_addr_high[55:48], it.client_addr_high[63:56]};
        end
      end
      3'd3: w = bswap64(it.client_addr_low);
      default: w = {MSG_LEN_V6, 56'd0};
    endcase
    return w;
  endfunction

endpackage

// ----- design/dsce_sip_core.sv -----
`timescale 1ns / 1ps
module dsce_sip_core
  import dsce_pkg::*;
(
  input  logic        clk,
  input  sip_cmd_t    cmd,
  input  logic [63:0] k0,
  input  logic [63:0] k1,
  output logic [63:0] digest
);

  logic [3:0][63:0] v;
  logic [3:0][63:0] v_next;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [3:0][63:0] sip_round(input logic [3:0][63:0] a);
    logic [3:0][63:0] t;
    t = a;
    t[0] = t[0] + t[1]; t[1] = rotl(t[1], 13); t[1] = t[1] ^ t[0]; t[0] = rotl(t[0], 32);
    t[2] = t[2] + t[3]; t[3] = rotl(t[3], 16); t[3] = t[3] ^ t[2];
    t[0] = t[0] + t[3]; t[3] = rotl(t[3], 21); t[3] = t[3] ^ t[0];
    t[2] = t[2] + t[1]; t[1] = rotl(t[1], 17); t[1] = t[1] ^ t[2]; t[2] = rotl(t[2], 32);
    return t;
  endfunction

  always_comb begin
    logic [3:0][63:0] t;
    t = v;
    v_next = v;
    case (cmd.op)
      SIP_INIT: begin
        v_next = {k1 ^ SIP_C3, k0 ^ SIP_C2, k1 ^ SIP_C1, k0 ^ SIP_C0};
      end
      SIP_ABSORB0: begin
        t[3] = t[3] ^ cmd.m;
        v_next = sip_round(t);
      end
      SIP_ABSORB1: begin
        t = sip_round(v);
        t[0] = t[0] ^ cmd.m;
        // finalization constant goes in right after the length block
        if (cmd.fin) begin
          t[2] = t[2] ^ FIN_XOR;
        end
        v_next = t;
      end
      SIP_ROUND: v_next = sip_round(v);
      default: v_next = v;
    endcase
  end

  always_ff @(posedge clk) begin
    v <= v_next;
  end

  assign digest = v[0] ^ v[1] ^ v[2] ^ v[3];

endmodule

// ----- design/dns_server_cookie_engine_core.sv -----
`timescale 1ns / 1ps
// one sipround per cycle in the shared round unit; a key pass runs init, two absorb steps per block
// (3 blocks for ipv4, 5 for ipv6), the final rounds and a compare; generate makes one pass, verify
// checks age and window first, then unless those fail makes one pass per key until a match, at most MAX_KEYS
// not ready while an item is at work; next item can be taken in the cycle after the result is loaded
// rst (synchronous, active high) clears the sequencer, output valid and the keys, and loads config defaults
module dns_server_cookie_engine_core
  import dsce_pkg::*;
#(
  parameter int MAX_KEYS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int SLOT_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  logic [63:0]      key_lo [MAX_KEYS];
  logic [63:0]      key_hi [MAX_KEYS];
  logic [KC_W-1:0]  key_count;
  logic [WIN_W-1:0] past_window;
  logic [WIN_W-1:0] future_window;
  logic [WIN_W-1:0] refresh_age;

  state_t           state;
  state_t           state_next;
  in_t              item;
  logic [63:0]      hdr;
  logic [31:0]      age;
  logic             refresh;
  logic [2:0]       blk;
  logic [1:0]       fin_cnt;
  logic [SLOT_W-1:0] slot;
  out_t             res;

  sip_cmd_t         cmd;
  logic [63:0]      digest;
  logic [63:0]      digest_be;
  logic [KC_W-1:0]  kc_eff;
  logic             slot_last;
  logic             last_blk;
  logic             win_bad;
  logic             refresh_now;
  logic             out_free;
  logic [KC_W-1:0]  cfg_slot;

  logic signed [32:0] age_x;
  logic signed [32:0] past_x;
  logic signed [32:0] fut_neg;
  logic signed [32:0] refresh_x;

  dsce_sip_core u_sip (
    .clk    (clk),
    .cmd    (cmd),
    .k0     (key_lo[slot]),
    .k1     (key_hi[slot]),
    .digest (digest)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign digest_be = bswap64(digest);
  assign cfg_slot  = KC_W'(cfg_index >> 1);

  // zero keys means one, more than the slots saturates
  assign kc_eff = (key_count == '0) ? KC_W'(1) :
                  (key_count > KC_W'(MAX_KEYS)) ? KC_W'(MAX_KEYS) : key_count;
  assign slot_last = (KC_W'(slot) + KC_W'(1)) >= kc_eff;
  assign last_blk  = (blk == ((item.addr_family == FAMILY_IPV6) ? LAST_BLK_V6 : LAST_BLK_V4));

  // serial age read as signed 32, windows are positive 31-bit
  assign age_x     = $signed({age[31], age});
  assign past_x    = $signed({2'b00, past_window});
  assign fut_neg   = -$signed({2'b00, future_window});
  assign refresh_x = $signed({2'b00, refresh_age});
  assign win_bad   = (item.cookie_len != COOKIE_BYTES) ||
                     (item.cookie_header[63:56] != COOKIE_VERSION) ||
                     (age_x > past_x) || (age_x < fut_neg);
  assign refresh_now = age_x > refresh_x;

  always_comb begin
    state_next = state;
    cmd        = '{op: SIP_NOP, m: '0, fin: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_item.func == FUNC_GENERATE) ? S_INIT : S_AGE;
        end
      end
      S_AGE:    state_next = S_WINDOW;
      S_WINDOW: state_next = win_bad ? S_RESULT : S_INIT;
      S_INIT: begin
        cmd.op     = SIP_INIT;
        state_next = S_ABS0;
      end
      S_ABS0: begin
        cmd.op     = SIP_ABSORB0;
        cmd.m      = msg_block(item, hdr, blk);
        state_next = S_ABS1;
      end
      S_ABS1: begin
        cmd.op     = SIP_ABSORB1;
        cmd.m      = msg_block(item, hdr, blk);
        cmd.fin    = last_blk;
        state_next = last_blk ? S_FINAL : S_ABS0;
      end
      S_FINAL: begin
        cmd.op = SIP_ROUND;
        if (fin_cnt == 2'd3) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (item.func == FUNC_GENERATE || digest_be == item.received_hash || slot_last) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_INIT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        key_lo[i] <= '0;
        key_hi[i] <= '0;
      end
      key_count     <= KC_W'(1);
      past_window   <= WIN_W'(3600);
      future_window <= WIN_W'(300);
      refresh_age   <= WIN_W'(1800);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY0_LOW, CFG_KEY1_LOW: begin
          if (int'(cfg_slot) < MAX_KEYS) begin
            key_lo[cfg_slot[SLOT_W-1:0]] <= cfg_data;
          end
        end
        CFG_KEY0_HIGH, CFG_KEY1_HIGH: begin
          if (int'(cfg_slot) < MAX_KEYS) begin
            key_hi[cfg_slot[SLOT_W-1:0]] <= cfg_data;
          end
        end
        CFG_KEY_COUNT:     key_count     <= cfg_data[KC_W-1:0];
        CFG_PAST_WINDOW:   past_window   <= cfg_data[WIN_W-1:0];
        CFG_FUTURE_WINDOW: future_window <= cfg_data[WIN_W-1:0];
        CFG_REFRESH_AGE:   refresh_age   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          item <= in_item;
          hdr  <= (in_item.func == FUNC_GENERATE) ?
                  {COOKIE_VERSION, 24'd0, in_item.time_now} : in_item.cookie_header;
          slot <= '0;
        end
      end
      S_AGE: age <= item.time_now - item.cookie_header[31:0];
      S_WINDOW: begin
        refresh <= refresh_now;
        res     <= '{status: ST_INVALID, header_out: '0, mac_out: '0};
      end
      S_INIT: begin
        blk     <= '0;
        fin_cnt <= '0;
      end
      S_ABS1:  blk     <= blk + 3'd1;
      S_FINAL: fin_cnt <= fin_cnt + 2'd1;
      S_CMP: begin
        if (item.func == FUNC_GENERATE) begin
          res <= '{status: ST_GENERATED, header_out: hdr, mac_out: digest_be};
        end else if (digest_be == item.received_hash) begin
          res <= '{status: refresh ? ST_VALID_REFRESH : ST_VALID, header_out: '0,
                   mac_out: '0};
        end else if (slot_last) begin
          res <= '{status: ST_INVALID, header_out: '0, mac_out: '0};
        end else begin
          slot <= slot + SLOT_W'(1);
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_item <= res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- design/dsce_checker.sv -----
`timescale 1ns / 1ps
module dsce_checker
  import dsce_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_t                 out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  // an accepted item keeps the block busy for its hash passes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again too soon");

  a_gen_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_GENERATED |->
      out_item.header_out[63:56] == COOKIE_VERSION && out_item.header_out[55:32] == 24'd0)
    else $error("generated header malformed");

  a_verify_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_GENERATED |->
      out_item.header_out == 64'd0 && out_item.mac_out == 64'd0)
    else $error("verify result carries header or mac");

endmodule

bind dns_server_cookie_engine_core dsce_checker u_dsce_checker (.*);
